FILE: hw/rtl/nfsl_pkg.sv
// Package for the nearest function symbol lookup: sizes, codes, the stored
// entry layout, sequencer states and the control bundle to the datapath.
// Depends on nothing; all RTL files but nfsl_ram refer to it by scoped names.
`default_nettype none

package nfsl_pkg;

  localparam int unsigned MAX_SYMBOLS = 1024;
  localparam int unsigned IDX_W       = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned LIM_W       = IDX_W + 1;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned NAME_W  = 32;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;

  localparam logic       OP_WRITE      = 1'b0;
  localparam logic       OP_QUERY      = 1'b1;
  localparam logic [3:0] KIND_FUNCTION = 4'h2;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [KIND_W-1:0] kind;
    logic [NAME_W-1:0] name;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Control from the sequencer to the compare datapath.
  typedef struct packed {
    logic clear;    // query accepted: capture address, forget best entry
    logic cand;     // table read data is valid this cycle
    logic finish;   // form the query result
    logic wr_done;  // a write item was taken: report an empty result
  } ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nfsl_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; width and depth come from the instantiating module.
`default_nettype none

module nfsl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nfsl_ctrl.sv
// Sequencer of the symbol lookup: accepts items, walks the table addresses
// during a query and drives the RAM port and the datapath control.
// Depends on nfsl_pkg.
`default_nettype none

module nfsl_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire logic                          op_i,
  input  wire logic [nfsl_pkg::SLOT_W-1:0]   entry_index_i,
  input  wire logic [nfsl_pkg::COUNT_W-1:0]  symbol_count_i,
  output logic                               busy,
  output logic                               ram_we_o,
  output logic                               ram_re_o,
  output logic [nfsl_pkg::IDX_W-1:0]         ram_addr_o,
  output nfsl_pkg::ctl_t                     ctl_o
);

  nfsl_pkg::state_e state_q, state_d;
  logic [nfsl_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [nfsl_pkg::LIM_W-1:0] limit_q, limit_d;
  logic                       rd_vld_q;
  logic                       accept;
  logic                       slot_ok;
  logic [nfsl_pkg::LIM_W-1:0] idx_next;
  logic [nfsl_pkg::LIM_W-1:0] limit_now;
  logic [31:0]                slot_ext;

  assign accept   = start && !busy;
  assign slot_ext = 32'(entry_index_i);
  assign slot_ok  = slot_ext < 32'(nfsl_pkg::MAX_SYMBOLS);
  assign idx_next = {1'b0, idx_q} + nfsl_pkg::LIM_W'(1);

  // A count above the table size scans the whole table.
  always_comb begin
    if (32'(symbol_count_i) > 32'(nfsl_pkg::MAX_SYMBOLS)) begin
      limit_now = nfsl_pkg::LIM_W'(nfsl_pkg::MAX_SYMBOLS);
    end else begin
      limit_now = nfsl_pkg::LIM_W'(symbol_count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nfsl_pkg::ST_IDLE;
      idx_q    <= '0;
      limit_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      limit_q  <= limit_d;
      rd_vld_q <= ram_re_o;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    limit_d      = limit_q;
    busy         = 1'b1;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    ram_addr_o   = idx_q;
    ctl_o        = '0;
    ctl_o.cand   = rd_vld_q;

    case (state_q)
      nfsl_pkg::ST_IDLE: begin
        busy       = 1'b0;
        ram_addr_o = nfsl_pkg::IDX_W'(slot_ext);
        if (start) begin
          if (op_i == nfsl_pkg::OP_WRITE) begin
            ram_we_o      = slot_ok;
            ctl_o.wr_done = 1'b1;
          end else begin
            ctl_o.clear = 1'b1;
            idx_d       = '0;
            limit_d     = limit_now;
            if (limit_now == '0) begin
              state_d = nfsl_pkg::ST_FINISH;
            end else begin
              state_d = nfsl_pkg::ST_SCAN;
            end
          end
        end
      end
      nfsl_pkg::ST_SCAN: begin
        ram_re_o = 1'b1;
        idx_d    = nfsl_pkg::IDX_W'(idx_next);
        if (idx_next == limit_q) begin
          state_d = nfsl_pkg::ST_DRAIN;
        end
      end
      nfsl_pkg::ST_DRAIN: begin
        // The last entry's read data is compared in this cycle.
        state_d = nfsl_pkg::ST_FINISH;
      end
      nfsl_pkg::ST_FINISH: begin
        ctl_o.finish = 1'b1;
        state_d      = nfsl_pkg::ST_IDLE;
      end
      default: begin
        state_d = nfsl_pkg::ST_IDLE;
      end
    endcase
  end

  // A write item never starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == nfsl_pkg::OP_WRITE) |=> (state_q == nfsl_pkg::ST_IDLE))
    else $error("write item left the sequencer busy");

  // Read data arrives only while a scan is running or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == nfsl_pkg::ST_SCAN || state_q == nfsl_pkg::ST_DRAIN))
    else $error("table read data outside a scan");

  // The scan index never reaches the scan limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nfsl_pkg::ST_SCAN) |-> ({1'b0, idx_q} < limit_q))
    else $error("scan index out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/nfsl_best.sv
// Compare datapath of the symbol lookup: tracks the best function entry seen
// during a scan with one shared subtractor, and registers the result.
// Depends on nfsl_pkg.
`default_nettype none

module nfsl_best (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire nfsl_pkg::ctl_t               ctl_i,
  input  wire logic [nfsl_pkg::ADDR_W-1:0]  query_addr_i,
  input  wire nfsl_pkg::entry_t             entry_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic [nfsl_pkg::NAME_W-1:0]       name_offset_o,
  output logic [nfsl_pkg::ADDR_W-1:0]       addr_offset_o
);

  logic [nfsl_pkg::ADDR_W-1:0] addr_q;
  logic [nfsl_pkg::ADDR_W-1:0] best_start_q;
  logic [nfsl_pkg::NAME_W-1:0] best_name_q;
  logic                        hit_q;
  logic [nfsl_pkg::ADDR_W-1:0] operand;
  logic [nfsl_pkg::ADDR_W:0]   diff;
  logic                        take;

  // The subtractor serves the range check during the scan and forms the
  // offset from the chosen start at the end.
  assign operand = ctl_i.finish ? best_start_q : entry_i.start;
  assign diff    = {1'b0, addr_q} - {1'b0, operand};

  // best_start_q starts at zero, so a start of zero can never be taken.
  assign take = ctl_i.cand && (entry_i.kind == nfsl_pkg::KIND_FUNCTION) &&
                !diff[nfsl_pkg::ADDR_W] && (entry_i.start > best_start_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      addr_q       <= query_addr_i;
      best_start_q <= '0;
    end else if (take) begin
      best_start_q <= entry_i.start;
      best_name_q  <= entry_i.name;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        hit_q <= 1'b0;
      end else if (take) begin
        hit_q <= 1'b1;
      end
      done_o <= ctl_i.finish || ctl_i.wr_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish && hit_q) begin
      found_o       <= 1'b1;
      name_offset_o <= best_name_q;
      addr_offset_o <= diff[nfsl_pkg::ADDR_W-1:0];
    end else if (ctl_i.finish || ctl_i.wr_done) begin
      found_o       <= 1'b0;
      name_offset_o <= '0;
      addr_offset_o <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nearest_function_symbol_lookup.sv
// Nearest function symbol lookup, top level.
//
// Channels: an item is transferred at a rising edge with start high and busy
// low. op_i selects a table write (entry_index_i, sym_start_i, sym_kind_i,
// sym_name_offset_i) or a query (query_addr_i). Every item gives exactly one
// result, shown on found_o, name_offset_o and addr_offset_o for one cycle
// while done_o is high; the receiver takes it in that cycle and cannot stall.
// symbol_count is written through cfg_we_i / cfg_wdata_i, by the user only while the
// block is idle; the block itself does not enforce this.
//
// A write result appears in the cycle after the transfer and busy stays low,
// so writes may follow back to back. A query with N entries to scan
// (N = min(symbol_count, table size)) keeps busy high while the table RAM is
// read one entry per cycle in the scan state and each entry goes through the
// shared compare unit, then through a drain state for the last read and a
// finish state that forms the offset; when N is zero only the finish state
// runs. The result strobe is high in the first cycle with busy low again.
//
// Reset clears the sequencer, the result strobe and symbol_count; table
// contents are not cleared and must be written before they are scanned.
`default_nettype none

module nearest_function_symbol_lookup (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          op_i,
  input  wire logic [nfsl_pkg::SLOT_W-1:0]   entry_index_i,
  input  wire logic [nfsl_pkg::ADDR_W-1:0]   sym_start_i,
  input  wire logic [nfsl_pkg::KIND_W-1:0]   sym_kind_i,
  input  wire logic [nfsl_pkg::NAME_W-1:0]   sym_name_offset_i,
  input  wire logic [nfsl_pkg::ADDR_W-1:0]   query_addr_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [nfsl_pkg::COUNT_W-1:0]  cfg_wdata_i,
  output logic                               done_o,
  output logic                               found_o,
  output logic [nfsl_pkg::NAME_W-1:0]        name_offset_o,
  output logic [nfsl_pkg::ADDR_W-1:0]        addr_offset_o
);

  logic [nfsl_pkg::COUNT_W-1:0] symbol_count_q;
  logic                         ram_we;
  logic                         ram_re;
  logic [nfsl_pkg::IDX_W-1:0]   ram_addr;
  nfsl_pkg::entry_t             wr_entry;
  nfsl_pkg::entry_t             rd_entry;
  nfsl_pkg::ctl_t               ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_count_q <= '0;
    end else if (cfg_we_i) begin
      symbol_count_q <= cfg_wdata_i;
    end
  end

  assign wr_entry.start = sym_start_i;
  assign wr_entry.kind  = sym_kind_i;
  assign wr_entry.name  = sym_name_offset_i;

  nfsl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .op_i           (op_i),
    .entry_index_i  (entry_index_i),
    .symbol_count_i (symbol_count_q),
    .busy           (busy),
    .ram_we_o       (ram_we),
    .ram_re_o       (ram_re),
    .ram_addr_o     (ram_addr),
    .ctl_o          (ctl)
  );

  nfsl_ram #(
    .WIDTH (nfsl_pkg::ENTRY_W),
    .DEPTH (nfsl_pkg::MAX_SYMBOLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (wr_entry),
    .rdata_o (rd_entry)
  );

  nfsl_best u_best (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .query_addr_i  (query_addr_i),
    .entry_i       (rd_entry),
    .done_o        (done_o),
    .found_o       (found_o),
    .name_offset_o (name_offset_o),
    .addr_offset_o (addr_offset_o)
  );

  // A result is never shown while the block still works on an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // A transferred write item gives its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == nfsl_pkg::OP_WRITE) |=> (done_o && !found_o))
    else $error("write result missing");

  // A query keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == nfsl_pkg::OP_QUERY) |=> busy)
    else $error("query did not start a scan");

  // An empty result carries zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (name_offset_o == '0 && addr_offset_o == '0))
    else $error("nonzero payload without a match");

endmodule

`default_nettype wire

FILE: sim/symbol_lookup_checker.sv
// Checker for the nearest function symbol lookup: watches the item, result and
// register channels, keeps its own copy of the symbol table and scan count,
// and compares every result with its prediction. Depends on nfsl_pkg.
module symbol_lookup_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          busy_i,
  input  wire logic                          op_i,
  input  wire logic [nfsl_pkg::SLOT_W-1:0]   entry_index_i,
  input  wire logic [nfsl_pkg::ADDR_W-1:0]   sym_start_i,
  input  wire logic [nfsl_pkg::KIND_W-1:0]   sym_kind_i,
  input  wire logic [nfsl_pkg::NAME_W-1:0]   sym_name_offset_i,
  input  wire logic [nfsl_pkg::ADDR_W-1:0]   query_addr_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [nfsl_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  wire logic                          done_i,
  input  wire logic                          found_i,
  input  wire logic [nfsl_pkg::NAME_W-1:0]   name_offset_i,
  input  wire logic [nfsl_pkg::ADDR_W-1:0]   addr_offset_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  typedef struct packed {
    logic                        found;
    logic [nfsl_pkg::NAME_W-1:0] name_offset;
    logic [nfsl_pkg::ADDR_W-1:0] addr_offset;
  } lookup_result_t;

  nfsl_pkg::entry_t                symtab [nfsl_pkg::MAX_SYMBOLS];
  lookup_result_t                  lookup_q [$];
  logic [nfsl_pkg::COUNT_W-1:0]    scan_count;
  int                              mismatch_total = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_total++;
    $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
  endtask

  // Nearest function entry at or below the address; a start of zero never
  // wins because the best start begins at zero and must be exceeded.
  function automatic lookup_result_t resolve_address(input logic [nfsl_pkg::ADDR_W-1:0] addr);
    lookup_result_t              res;
    int unsigned                 span;
    int unsigned                 best_idx;
    logic [nfsl_pkg::ADDR_W-1:0] best_start;
    logic                        hit;
    res        = '0;
    span       = (scan_count > nfsl_pkg::MAX_SYMBOLS) ? nfsl_pkg::MAX_SYMBOLS : scan_count;
    best_idx   = 0;
    best_start = '0;
    hit        = 1'b0;
    for (int unsigned i = 0; i < span; i++) begin
      if (symtab[i].kind == nfsl_pkg::KIND_FUNCTION && addr >= symtab[i].start &&
          symtab[i].start > best_start) begin
        best_start = symtab[i].start;
        best_idx   = i;
        hit        = 1'b1;
      end
    end
    if (hit) begin
      res.found       = 1'b1;
      res.name_offset = symtab[best_idx].name;
      res.addr_offset = addr - best_start;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      lookup_q.delete();
      scan_count = '0;
    end else begin
      // Results leave before the item of this edge is queued: a result never
      // belongs to an item transferred at the same edge.
      if (done_i) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", {63'b0, found_i}, 64'b0);
        end else begin
          want = lookup_q.pop_front();
          if (found_i !== want.found)
            report_mismatch("found", {63'b0, found_i}, {63'b0, want.found});
          if (name_offset_i !== want.name_offset)
            report_mismatch("name_offset", {32'b0, name_offset_i}, {32'b0, want.name_offset});
          if (addr_offset_i !== want.addr_offset)
            report_mismatch("addr_offset", addr_offset_i, want.addr_offset);
        end
      end
      if (cfg_we_i) scan_count = cfg_wdata_i;
      if (start_i && !busy_i) begin
        if (op_i == nfsl_pkg::OP_WRITE) begin
          symtab[entry_index_i] = '{start: sym_start_i, kind: sym_kind_i,
                                    name: sym_name_offset_i};
          lookup_q.push_back('0);
        end else begin
          lookup_q.push_back(resolve_address(query_addr_i));
        end
      end
    end
    fail_count_o <= mismatch_total;
    pending_o    <= lookup_q.size();
  end

endmodule

FILE: sim/testbench.sv
// Top of the simulation for the nearest function symbol lookup: clock, reset,
// table writes, queries and scan count settings, and the final verdict.
// Depends on nfsl_pkg, the block itself and symbol_lookup_checker.
module testbench;

  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int unsigned LOADED_SYMBOLS = 256;
  localparam logic [63:0] CLUSTER_BASE   = 64'h0000_5A5A_0010_0000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic                          op;
  logic [nfsl_pkg::SLOT_W-1:0]   entry_index;
  logic [nfsl_pkg::ADDR_W-1:0]   sym_start;
  logic [nfsl_pkg::KIND_W-1:0]   sym_kind;
  logic [nfsl_pkg::NAME_W-1:0]   sym_name_offset;
  logic [nfsl_pkg::ADDR_W-1:0]   query_addr;
  logic                          cfg_we;
  logic [nfsl_pkg::COUNT_W-1:0]  cfg_wdata;
  logic                          done;
  logic                          found;
  logic [nfsl_pkg::NAME_W-1:0]   name_offset;
  logic [nfsl_pkg::ADDR_W-1:0]   addr_offset;

  int                            mismatches;
  int                            outstanding;
  int unsigned                   cycle_count = 0;
  int unsigned                   idle_pct;
  int unsigned                   scan_count;
  logic [nfsl_pkg::ADDR_W-1:0]   start_shadow [nfsl_pkg::MAX_SYMBOLS];

  nearest_function_symbol_lookup u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .op_i              (op),
    .entry_index_i     (entry_index),
    .sym_start_i       (sym_start),
    .sym_kind_i        (sym_kind),
    .sym_name_offset_i (sym_name_offset),
    .query_addr_i      (query_addr),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .done_o            (done),
    .found_o           (found),
    .name_offset_o     (name_offset),
    .addr_offset_o     (addr_offset)
  );

  symbol_lookup_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .op_i              (op),
    .entry_index_i     (entry_index),
    .sym_start_i       (sym_start),
    .sym_kind_i        (sym_kind),
    .sym_name_offset_i (sym_name_offset),
    .query_addr_i      (query_addr),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .done_i            (done),
    .found_i           (found),
    .name_offset_i     (name_offset),
    .addr_offset_i     (addr_offset),
    .fail_count_o      (mismatches),
    .pending_o         (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Number of leading entries a query currently scans, or the whole table
  // when the count is zero so that writes still spread over every slot.
  function automatic int unsigned live_span();
    if (scan_count == 0) return nfsl_pkg::MAX_SYMBOLS;
    return (scan_count > nfsl_pkg::MAX_SYMBOLS) ? nfsl_pkg::MAX_SYMBOLS : scan_count;
  endfunction

  function automatic logic [63:0] pick_start();
    case ($urandom_range(9))
      0:       return 64'h0;
      1:       return {64{1'b1}} - $urandom_range(3);
      2:       return {$urandom, $urandom};
      3:       return start_shadow[$urandom_range(live_span() - 1)];
      default: return CLUSTER_BASE + $urandom_range(8191);
    endcase
  endfunction

  function automatic logic [3:0] pick_kind();
    if ($urandom_range(99) < 65) return nfsl_pkg::KIND_FUNCTION;
    return 4'($urandom_range(15));
  endfunction

  // Half of the query addresses land on, just below or just above a live start.
  function automatic logic [63:0] pick_query_addr();
    int unsigned j;
    j = $urandom_range(live_span() - 1);
    case ($urandom_range(9))
      0:       return 64'h0;
      1:       return {64{1'b1}};
      2:       return {$urandom, $urandom};
      3, 4:    return start_shadow[j];
      5:       return start_shadow[j] - 1;
      6, 7:    return start_shadow[j] + $urandom_range(1, 300);
      default: return CLUSTER_BASE + $urandom_range(9000);
    endcase
  endfunction

  task automatic send_item(input logic item_op, input logic [9:0] idx,
                           input logic [63:0] s, input logic [3:0] k,
                           input logic [31:0] nm, input logic [63:0] qa);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    op              = item_op;
    entry_index     = idx;
    sym_start       = s;
    sym_kind        = k;
    sym_name_offset = nm;
    query_addr      = qa;
    start           = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (item_op == nfsl_pkg::OP_WRITE) start_shadow[idx] = s;
  endtask

  task automatic write_entry(input logic [9:0] idx, input logic [63:0] s,
                             input logic [3:0] k, input logic [31:0] nm);
    send_item(nfsl_pkg::OP_WRITE, idx, s, k, nm, {$urandom, $urandom});
  endtask

  task automatic lookup(input logic [63:0] qa);
    send_item(nfsl_pkg::OP_QUERY, 10'($urandom_range(1023)), {$urandom, $urandom},
              4'($urandom_range(15)), $urandom, qa);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (outstanding != 0 || busy) @(posedge clk_i);
  endtask

  task automatic set_scan_count(input int unsigned value);
    wait_drained();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value[nfsl_pkg::COUNT_W-1:0];
    @(negedge clk_i);
    cfg_we     = 1'b0;
    scan_count = value;
  endtask

  task automatic random_item();
    logic [9:0] idx;
    if ($urandom_range(99) < 45) begin
      if ($urandom_range(3) != 0) idx = 10'($urandom_range(live_span() - 1));
      else idx = 10'($urandom_range(1023));
      write_entry(idx, pick_start(), pick_kind(), $urandom);
    end else begin
      lookup(pick_query_addr());
    end
  endtask

  initial begin
    int unsigned big_count [3];
    int unsigned seg_items;
    start           = 1'b0;
    op              = nfsl_pkg::OP_WRITE;
    entry_index     = '0;
    sym_start       = '0;
    sym_kind        = '0;
    sym_name_offset = '0;
    query_addr      = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rst_ni          = 1'b0;
    idle_pct        = 0;
    scan_count      = 0;
    big_count       = '{LOADED_SYMBOLS, LOADED_SYMBOLS - 1, LOADED_SYMBOLS / 2 + 1};
    foreach (start_shadow[i]) start_shadow[i] = CLUSTER_BASE;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The scan count is zero out of reset, so nothing matches.
    lookup({64{1'b1}});
    write_entry(0, 64'h0, nfsl_pkg::KIND_FUNCTION, 32'hA5A5_0000);
    write_entry(1, 64'h1000, nfsl_pkg::KIND_FUNCTION, 32'hFFFF_FFFF);
    // Same start as entry 1: the lower index must win the tie.
    write_entry(2, 64'h1000, nfsl_pkg::KIND_FUNCTION, 32'h1234_5678);
    write_entry(3, 64'h2000, 4'h3, 32'h0000_3333);
    write_entry(4, {64{1'b1}}, nfsl_pkg::KIND_FUNCTION, 32'h0);
    write_entry(5, 64'h1800, 4'hF, 32'h5555_5555);
    set_scan_count(6);
    lookup(64'h0);
    lookup(64'hFFF);
    lookup(64'h1000);
    lookup(64'h2FFF);
    lookup({64{1'b1}});
    lookup({64{1'b1}} - 1);
    // Only the entry at address zero is scanned, and it never matches.
    set_scan_count(1);
    lookup({64{1'b1}});
    set_scan_count(3);
    lookup(64'h1800);

    // Load a prefix of the table; every scan count used below stays inside it,
    // so queries read written entries only.
    wait_drained();
    for (int unsigned i = 0; i < LOADED_SYMBOLS; i++)
      write_entry(10'(i), pick_start(), pick_kind(), $urandom);

    // Random part: one long-scan segment per mode (whole prefix in mode 0), the rest short.
    for (int unsigned mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 8 : (mode == 1) ? 54 : 0;
      for (int unsigned seg = 0; seg < 8; seg++) begin
        if (seg == 0) begin
          set_scan_count(big_count[mode]);
          seg_items = 8;
        end else begin
          set_scan_count(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 48));
          seg_items = 14;
        end
        repeat (seg_items) begin
          if ($urandom_range(49) == 0) wait_drained();
          random_item();
        end
      end
    end

    wait_drained();
    repeat (1030) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/nfsl_pkg.sv
hw/rtl/nfsl_ram.sv
hw/rtl/nfsl_ctrl.sv
hw/rtl/nfsl_best.sv
hw/rtl/nearest_function_symbol_lookup.sv
sim/symbol_lookup_checker.sv
sim/testbench.sv
